/* src/lvno_pkg.sv */
// package: constants, hash table and helper functions for lattice value noise
`timescale 1ns / 1ps
`default_nettype none
package lvno_pkg;
  localparam int unsigned Octaves = 7;
  localparam int unsigned FracBits = 16;
  localparam int unsigned GenMax = 24;
  localparam int unsigned OutWidth = FracBits + 2;
  localparam int unsigned GenWidth = 5;

  typedef enum logic [0:0] {
    CfgGenerations = 1'b0,
    CfgSeed        = 1'b1
  } cfg_index_e;

  typedef logic [FracBits-1:0] frac_t;
  typedef logic signed [FracBits+1:0] corner_t;

  function automatic logic [31:0] mix_lookup(input logic [7:0] idx);
    logic [31:0] r;
    case (idx)
      8'd0: r = 32'h0a881716; 8'd1: r = 32'h20daa8ee; 8'd2: r = 32'h61eb7d78;
      8'd3: r = 32'h46164e74; 8'd4: r = 32'h39ab9d9d; 8'd5: r = 32'h633a33f6;
      8'd6: r = 32'h437c821d; 8'd7: r = 32'h60a66f29; 8'd8: r = 32'hc4ae45ab;
      8'd9: r = 32'h9a5cb3ce; 8'd10: r = 32'h4a43606a; 8'd11: r = 32'h56802c3c;
      8'd12: r = 32'he40d5e25; 8'd13: r = 32'ha0297f41; 8'd14: r = 32'h0457671e;
      8'd15: r = 32'hf167ab77; 8'd16: r = 32'h571276db; 8'd17: r = 32'h8b644e02;
      8'd18: r = 32'hd5cfc592; 8'd19: r = 32'h2331bfa2; 8'd20: r = 32'hf9dfe7c1;
      8'd21: r = 32'hce9e7583; 8'd22: r = 32'hfb133c29; 8'd23: r = 32'h951c31c9;
      8'd24: r = 32'h8e61b24e; 8'd25: r = 32'hddf37570; 8'd26: r = 32'h938c3b72;
      8'd27: r = 32'haf907468; 8'd28: r = 32'h98b77ac7; 8'd29: r = 32'he6edd515;
      8'd30: r = 32'ha01f3600; 8'd31: r = 32'heafea5ad; 8'd32: r = 32'h83fcce08;
      8'd33: r = 32'he2e9fa9d; 8'd34: r = 32'hd87727bb; 8'd35: r = 32'h1945ea4c;
      8'd36: r = 32'h831d295f; 8'd37: r = 32'ha796ed85; 8'd38: r = 32'haa907b24;
      8'd39: r = 32'h69b25f12; 8'd40: r = 32'hd4b27868; 8'd41: r = 32'hdcde40f5;
      8'd42: r = 32'h0e9e6def; 8'd43: r = 32'h348a4702; 8'd44: r = 32'h298389c8;
      8'd45: r = 32'hce405b63; 8'd46: r = 32'h2e36d5a3; 8'd47: r = 32'hf0569882;
      8'd48: r = 32'h3beb3219; 8'd49: r = 32'hf2366b9a; 8'd50: r = 32'h69576cca;
      8'd51: r = 32'hd2725b8b; 8'd52: r = 32'h6016d6f3; 8'd53: r = 32'h728142ca;
      8'd54: r = 32'h448b9f47; 8'd55: r = 32'he600cd4e; 8'd56: r = 32'hac45d524;
      8'd57: r = 32'h0e32531b; 8'd58: r = 32'h425d7b55; 8'd59: r = 32'hc65cd9dc;
      8'd60: r = 32'h58d7f9f1; 8'd61: r = 32'h19f49822; 8'd62: r = 32'h6786f2d3;
      8'd63: r = 32'h57844748; 8'd64: r = 32'h523de4a3; 8'd65: r = 32'h01079655;
      8'd66: r = 32'h6dccea89; 8'd67: r = 32'hb59278f2; 8'd68: r = 32'h13a27e83;
      8'd69: r = 32'h19bcfc69; 8'd70: r = 32'h4cff4bf5; 8'd71: r = 32'hb18a3441;
      8'd72: r = 32'h1e235c5e; 8'd73: r = 32'ha1b47a42; 8'd74: r = 32'h3bee8a5a;
      8'd75: r = 32'ha0962594; 8'd76: r = 32'ha9b1ce4c; 8'd77: r = 32'hb00399c8;
      8'd78: r = 32'h83749847; 8'd79: r = 32'h42c666e7; 8'd80: r = 32'h08b81e57;
      8'd81: r = 32'hf7eee24b; 8'd82: r = 32'h66720817; 8'd83: r = 32'h3983f5f8;
      8'd84: r = 32'h4999a817; 8'd85: r = 32'h94fabd7a; 8'd86: r = 32'h7aa775ef;
      8'd87: r = 32'hf6c1adcb; 8'd88: r = 32'h5f32a695; 8'd89: r = 32'h813ecf7e;
      8'd90: r = 32'h66615fd5; 8'd91: r = 32'hc0012e15; 8'd92: r = 32'h051dd97e;
      8'd93: r = 32'he6ee2803; 8'd94: r = 32'h2449663c; 8'd95: r = 32'h4024d59c;
      8'd96: r = 32'hcb70a774; 8'd97: r = 32'hacd3db94; 8'd98: r = 32'h1845484e;
      8'd99: r = 32'hc803ef3c; 8'd100: r = 32'h0662876f; 8'd101: r = 32'h8794fe30;
      8'd102: r = 32'hf0f0d16a; 8'd103: r = 32'h41c065b8; 8'd104: r = 32'hff9d5fc7;
      8'd105: r = 32'ha4237394; 8'd106: r = 32'h8656614d; 8'd107: r = 32'h26be5da9;
      8'd108: r = 32'hb32bc625; 8'd109: r = 32'hf215cc58; 8'd110: r = 32'hc1e21848;
      8'd111: r = 32'hb97fe9fc; 8'd112: r = 32'hbb28ef04; 8'd113: r = 32'hde88eb23;
      8'd114: r = 32'he0623033; 8'd115: r = 32'ha3df9e9c; 8'd116: r = 32'he9b95887;
      8'd117: r = 32'h3a4ab03b; 8'd118: r = 32'h1cba812e; 8'd119: r = 32'h174b4b37;
      8'd120: r = 32'h0074d24b; 8'd121: r = 32'he5668d09; 8'd122: r = 32'hf11a070a;
      8'd123: r = 32'h2884252b; 8'd124: r = 32'h911149ea; 8'd125: r = 32'h20dab459;
      8'd126: r = 32'h89573d33; 8'd127: r = 32'h68c2711d; 8'd128: r = 32'h2b8e9781;
      8'd129: r = 32'hf007567b; 8'd130: r = 32'h9761c8fa; 8'd131: r = 32'h574d3a4e;
      8'd132: r = 32'ha2ac28dd; 8'd133: r = 32'h924f2211; 8'd134: r = 32'hb0a91028;
      8'd135: r = 32'h83a90487; 8'd136: r = 32'hf22cf6f8; 8'd137: r = 32'h17a5dcfe;
      8'd138: r = 32'h10497534; 8'd139: r = 32'h27dd1316; 8'd140: r = 32'h94a34815;
      8'd141: r = 32'h276e11ee; 8'd142: r = 32'head1d779; 8'd143: r = 32'h0bfd4f20;
      8'd144: r = 32'h45f2228f; 8'd145: r = 32'h35d21bf8; 8'd146: r = 32'h121336c0;
      8'd147: r = 32'h43a6538b; 8'd148: r = 32'h55e950dc; 8'd149: r = 32'h88a80871;
      8'd150: r = 32'hfda9f61e; 8'd151: r = 32'h5c76d120; 8'd152: r = 32'h2eb8338f;
      8'd153: r = 32'h5193bb8e; 8'd154: r = 32'h30a6995c; 8'd155: r = 32'h500505a8;
      8'd156: r = 32'h7b214f6a; 8'd157: r = 32'h6a74558d; 8'd158: r = 32'h040d0716;
      8'd159: r = 32'h4452846b; 8'd160: r = 32'hd0a0e838; 8'd161: r = 32'head282e0;
      8'd162: r = 32'h6bc6465c; 8'd163: r = 32'hcb4ab107; 8'd164: r = 32'hab990ed7;
      8'd165: r = 32'h72a1fe7b; 8'd166: r = 32'h06901fdf; 8'd167: r = 32'h18f90739;
      8'd168: r = 32'h8cd2b861; 8'd169: r = 32'haea9d40c; 8'd170: r = 32'h2dcf7c18;
      8'd171: r = 32'h45979e8a; 8'd172: r = 32'h10393f0d; 8'd173: r = 32'h3209d7c9;
      8'd174: r = 32'h2c71378f; 8'd175: r = 32'h908a692a; 8'd176: r = 32'hc0e63b24;
      8'd177: r = 32'h05de3118; 8'd178: r = 32'hfc974436; 8'd179: r = 32'h1be44823;
      8'd180: r = 32'h03de2f3d; 8'd181: r = 32'h66cfb6e4; 8'd182: r = 32'h52727bfc;
      8'd183: r = 32'ha7b93651; 8'd184: r = 32'hd7b9035f; 8'd185: r = 32'hfac28d33;
      8'd186: r = 32'h59bb4457; 8'd187: r = 32'heede4004; 8'd188: r = 32'h175ad747;
      8'd189: r = 32'h7808d123; 8'd190: r = 32'hc9c97de8; 8'd191: r = 32'h0c26ca26;
      8'd192: r = 32'h75e62e96; 8'd193: r = 32'hc8376e97; 8'd194: r = 32'hf2ee6baa;
      8'd195: r = 32'h6a885f88; 8'd196: r = 32'h352f92ab; 8'd197: r = 32'h4143f4a4;
      8'd198: r = 32'hb1cca58c; 8'd199: r = 32'he8fbea94; 8'd200: r = 32'h5c306621;
      8'd201: r = 32'hfbe64c32; 8'd202: r = 32'ha1ed285d; 8'd203: r = 32'hca7395cf;
      8'd204: r = 32'h4eed31a5; 8'd205: r = 32'h31e39fee; 8'd206: r = 32'h7951c585;
      8'd207: r = 32'h23434811; 8'd208: r = 32'hfc103036; 8'd209: r = 32'hef001b3c;
      8'd210: r = 32'h499f5f34; 8'd211: r = 32'h5f7f38f4; 8'd212: r = 32'h0206d8c5;
      8'd213: r = 32'hcc3ee4f1; 8'd214: r = 32'hbc0b485c; 8'd215: r = 32'h4e4f5829;
      8'd216: r = 32'h05ee6e6d; 8'd217: r = 32'hc82d5353; 8'd218: r = 32'h44892bec;
      8'd219: r = 32'h22984b53; 8'd220: r = 32'h8a6374d1; 8'd221: r = 32'h0850c3f9;
      8'd222: r = 32'h0c06ae88; 8'd223: r = 32'h2dfdc126; 8'd224: r = 32'hd1edacdc;
      8'd225: r = 32'h1d8dbd39; 8'd226: r = 32'hdeff2db8; 8'd227: r = 32'hd557278d;
      8'd228: r = 32'h7e9e3740; 8'd229: r = 32'h49a1ecb5; 8'd230: r = 32'h43f7b391;
      8'd231: r = 32'h50b6b9ef; 8'd232: r = 32'h46b9b8f8; 8'd233: r = 32'hd3f5f6d2;
      8'd234: r = 32'h8d453b88; 8'd235: r = 32'hc0ba5333; 8'd236: r = 32'h5ab92e37;
      8'd237: r = 32'h6e7620a4; 8'd238: r = 32'h8eb9795a; 8'd239: r = 32'h30355a84;
      8'd240: r = 32'hf5e4ad33; 8'd241: r = 32'h7d0b4df2; 8'd242: r = 32'he0f3e2a1;
      8'd243: r = 32'ha466f0e6; 8'd244: r = 32'h39a19c9a; 8'd245: r = 32'h1b284524;
      8'd246: r = 32'h854f8b3b; 8'd247: r = 32'h02d10b6c; 8'd248: r = 32'h44fb5d9d;
      8'd249: r = 32'h60c29fec; 8'd250: r = 32'hda35244a; 8'd251: r = 32'hb5ce6653;
      8'd252: r = 32'hfd8356ad; 8'd253: r = 32'hff88d46b; 8'd254: r = 32'h23fd1d16;
      default: r = 32'hdc0be23c;
    endcase
    return r;
  endfunction

  // two table rounds of the hash
  function automatic logic [31:0] mix_half_a(input logic [31:0] k);
    logic [31:0] t;
    t = k ^ mix_lookup(k[7:0]);
    t = t ^ mix_lookup(t[15:8]);
    return t;
  endfunction

  function automatic logic [31:0] mix_half_b(input logic [31:0] k);
    logic [31:0] t;
    t = k ^ mix_lookup(k[23:16]);
    t = t ^ mix_lookup(t[31:24]);
    return t;
  endfunction

  function automatic corner_t corner_of(input logic [31:0] h);
    return $signed({1'b0, h[31:31-FracBits]}) - $signed(corner_t'(1 << FracBits));
  endfunction
endpackage
`default_nettype wire

/* src/lvno_octave.sv */
// one octave: lattice keys, hash, smoothing and bilinear blend, six register stages
`timescale 1ns / 1ps
`default_nettype none
module lvno_octave (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [31:0]                   x_i,
  input  wire logic [31:0]                   y_i,
  input  wire logic [4:0]                    g_i,
  input  wire logic [4:0]                    gen_i,
  input  wire logic [31:0]                   seed_i,
  output logic signed [lvno_pkg::FracBits+1:0] p_o
);
  import lvno_pkg::*;

  logic [31:0] key_q [4];
  frac_t       fx_q, fy_q;
  logic [31:0] ha_q [4];
  frac_t       fx2_q, fy2_q;
  frac_t       fx3_q, fy3_q;
  frac_t       fxr_q, fyr_q;
  corner_t     c_q [4];
  frac_t       sx_q, sy_q;
  corner_t     c4_q [4];
  frac_t       sx4_q;
  corner_t     p0_q, p1_q;

  logic [31:0] xl, yl, xs, ys, xk, xk1;
  logic [FracBits:0] three;
  logic [2*FracBits-1:0] sqx, sqy;
  frac_t f2x, f2y;
  logic [FracBits+1:0] tx, ty;
  logic [2*FracBits+1:0] mx, my;
  logic signed [FracBits+2:0] d0, d1, d2;
  logic signed [2*FracBits+3:0] e0, e1, e2;

  always_comb begin
    xl  = x_i >> (6'd32 - {1'b0, g_i});
    yl  = y_i >> (6'd32 - {1'b0, g_i});
    xs  = x_i << g_i;
    ys  = y_i << g_i;
    xk  = ((seed_i << gen_i) | xl) << gen_i;
    xk1 = ((seed_i << gen_i) | (xl + 32'd1)) << gen_i;
    three = (FracBits + 1)'(3);
    sqx = fx2_q * fx2_q;
    sqy = fy2_q * fy2_q;
    f2x = sqx[2*FracBits-1:FracBits];
    f2y = sqy[2*FracBits-1:FracBits];
    tx  = {three[1:0], {FracBits{1'b0}}} - {1'b0, fxr_q, 1'b0};
    ty  = {three[1:0], {FracBits{1'b0}}} - {1'b0, fyr_q, 1'b0};
    mx  = fx3_q * tx;
    my  = fy3_q * ty;
    d0  = (FracBits + 3)'(c4_q[1]) - (FracBits + 3)'(c4_q[0]);
    d1  = (FracBits + 3)'(c4_q[3]) - (FracBits + 3)'(c4_q[2]);
    d2  = (FracBits + 3)'(p1_q) - (FracBits + 3)'(p0_q);
    e0  = d0 * $signed({1'b0, sy_q});
    e1  = d1 * $signed({1'b0, sy_q});
    e2  = d2 * $signed({1'b0, sx4_q});
  end

  // stage 3 holds the square and the plain fraction side by side for the smoothstep product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      key_q[0] <= xk | yl;
      key_q[1] <= xk | (yl + 32'd1);
      key_q[2] <= xk1 | yl;
      key_q[3] <= xk1 | (yl + 32'd1);
      fx_q <= xs[31:32-FracBits];
      fy_q <= ys[31:32-FracBits];
      for (int i = 0; i < 4; i++) ha_q[i] <= mix_half_a(key_q[i]);
      fx2_q <= fx_q;
      fy2_q <= fy_q;
      for (int i = 0; i < 4; i++) c_q[i] <= corner_of(mix_half_b(ha_q[i]));
      fx3_q <= f2x;
      fy3_q <= f2y;
      fxr_q <= fx2_q;
      fyr_q <= fy2_q;
      sx_q <= mx[2*FracBits-1:FracBits];
      sy_q <= my[2*FracBits-1:FracBits];
      for (int i = 0; i < 4; i++) c4_q[i] <= c_q[i];
      sx4_q <= sx_q;
      p0_q <= c4_q[0] + corner_t'(e0 >>> FracBits);
      p1_q <= c4_q[2] + corner_t'(e1 >>> FracBits);
      p_o  <= p0_q + corner_t'(e2 >>> FracBits);
    end
  end
endmodule
`default_nettype wire

/* src/lattice_value_noise_octaves.sv */
// top level: config registers, seven parallel octave pipelines and the weighted sum
//
//  channel | direction | handshake          | word
//  in      | input     | in_valid_i/in_stall_o   | x_coord_i, y_coord_i
//  out     | output    | out_valid_o/out_stall_i | noise_value_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one word accepted per cycle while the output word is not stalled
// six stages inside each octave unit, then a registered sum and saturation
// the whole pipeline holds when the output word is stalled
// reset clears valid bits and sets generations to 10, seed to 0
`timescale 1ns / 1ps
`default_nettype none
module lattice_value_noise_octaves (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [31:0]                          x_coord_i,
  input  wire logic [31:0]                          y_coord_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [lvno_pkg::OutWidth-1:0]      noise_value_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [0:0]                           cfg_index_i,
  input  wire logic [31:0]                          cfg_data_i
);
  import lvno_pkg::*;

  localparam int unsigned Depth = 7;

  logic [GenWidth-1:0] generations_q;
  logic [31:0]         seed_q;
  logic [GenWidth-1:0] gen;
  logic [Depth-1:0]    vld_q;
  logic                en;
  logic signed [FracBits+1:0] p [Octaves];
  logic signed [FracBits+Octaves+2:0] sum_d;
  logic signed [FracBits+2:0] tot;
  logic signed [OutWidth-1:0] res_q;

  assign cfg_ready_o = 1'b1;
  assign en = !(vld_q[Depth-1] && out_stall_i);
  assign in_stall_o = !en;
  assign out_valid_o = vld_q[Depth-1];
  assign noise_value_o = res_q;

  always_comb begin
    gen = generations_q;
    if (gen < GenWidth'(Octaves + 1)) gen = GenWidth'(Octaves + 1);
    if (gen > GenWidth'(GenMax)) gen = GenWidth'(GenMax);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      generations_q <= GenWidth'(10);
      seed_q <= '0;
      vld_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_e'(cfg_index_i))
          CfgGenerations: generations_q <= cfg_data_i[GenWidth-1:0];
          CfgSeed:        seed_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (en) vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  for (genvar k = 0; k < Octaves; k++) begin : g_oct
    lvno_octave u_oct (
      .clk_i  (clk_i),
      .en_i   (en),
      .x_i    (x_coord_i),
      .y_i    (y_coord_i),
      .g_i    (gen - GenWidth'(Octaves - k)),
      .gen_i  (gen),
      .seed_i (seed_q),
      .p_o    (p[k])
    );
  end

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < Octaves; k++)
      sum_d = sum_d + ((FracBits + Octaves + 3)'(p[k]) <<< (Octaves - 1 - k));
    tot = (FracBits + 3)'(sum_d >>> Octaves);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (tot > (FracBits + 3)'(1 << FracBits))
        res_q <= OutWidth'(1 << FracBits);
      else if (tot < -$signed((FracBits + 3)'(1 << FracBits)))
        res_q <= -$signed(OutWidth'(1 << FracBits));
      else
        res_q <= OutWidth'(tot);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("pipeline moved under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(noise_value_o)))
    else $error("stalled word changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (noise_value_o <= OutWidth'(1 << FracBits)
      && noise_value_o >= -$signed(OutWidth'(1 << FracBits))))
    else $error("result out of range");
endmodule
`default_nettype wire

/* tb/lattice_value_noise_octaves_test.sv */
// testbench: fractal value noise block checked against a fixed-point noise predictor
`timescale 1ns / 1ps

class noise_scoreboard;
  bit [4:0] generations;
  bit [31:0] seed;
  logic signed [17:0] pending_noise[$];
  int mismatches;
  bit [31:0] sbox[256];

  function new();
    bit [31:0] t[256] = '{
      32'h0a881716, 32'h20daa8ee, 32'h61eb7d78, 32'h46164e74, 32'h39ab9d9d, 32'h633a33f6,
      32'h437c821d, 32'h60a66f29, 32'hc4ae45ab, 32'h9a5cb3ce, 32'h4a43606a, 32'h56802c3c,
      32'he40d5e25, 32'ha0297f41, 32'h0457671e, 32'hf167ab77, 32'h571276db, 32'h8b644e02,
      32'hd5cfc592, 32'h2331bfa2, 32'hf9dfe7c1, 32'hce9e7583, 32'hfb133c29, 32'h951c31c9,
      32'h8e61b24e, 32'hddf37570, 32'h938c3b72, 32'haf907468, 32'h98b77ac7, 32'he6edd515,
      32'ha01f3600, 32'heafea5ad, 32'h83fcce08, 32'he2e9fa9d, 32'hd87727bb, 32'h1945ea4c,
      32'h831d295f, 32'ha796ed85, 32'haa907b24, 32'h69b25f12, 32'hd4b27868, 32'hdcde40f5,
      32'h0e9e6def, 32'h348a4702, 32'h298389c8, 32'hce405b63, 32'h2e36d5a3, 32'hf0569882,
      32'h3beb3219, 32'hf2366b9a, 32'h69576cca, 32'hd2725b8b, 32'h6016d6f3, 32'h728142ca,
      32'h448b9f47, 32'he600cd4e, 32'hac45d524, 32'h0e32531b, 32'h425d7b55, 32'hc65cd9dc,
      32'h58d7f9f1, 32'h19f49822, 32'h6786f2d3, 32'h57844748, 32'h523de4a3, 32'h01079655,
      32'h6dccea89, 32'hb59278f2, 32'h13a27e83, 32'h19bcfc69, 32'h4cff4bf5, 32'hb18a3441,
      32'h1e235c5e, 32'ha1b47a42, 32'h3bee8a5a, 32'ha0962594, 32'ha9b1ce4c, 32'hb00399c8,
      32'h83749847, 32'h42c666e7, 32'h08b81e57, 32'hf7eee24b, 32'h66720817, 32'h3983f5f8,
      32'h4999a817, 32'h94fabd7a, 32'h7aa775ef, 32'hf6c1adcb, 32'h5f32a695, 32'h813ecf7e,
      32'h66615fd5, 32'hc0012e15, 32'h051dd97e, 32'he6ee2803, 32'h2449663c, 32'h4024d59c,
      32'hcb70a774, 32'hacd3db94, 32'h1845484e, 32'hc803ef3c, 32'h0662876f, 32'h8794fe30,
      32'hf0f0d16a, 32'h41c065b8, 32'hff9d5fc7, 32'ha4237394, 32'h8656614d, 32'h26be5da9,
      32'hb32bc625, 32'hf215cc58, 32'hc1e21848, 32'hb97fe9fc, 32'hbb28ef04, 32'hde88eb23,
      32'he0623033, 32'ha3df9e9c, 32'he9b95887, 32'h3a4ab03b, 32'h1cba812e, 32'h174b4b37,
      32'h0074d24b, 32'he5668d09, 32'hf11a070a, 32'h2884252b, 32'h911149ea, 32'h20dab459,
      32'h89573d33, 32'h68c2711d, 32'h2b8e9781, 32'hf007567b, 32'h9761c8fa, 32'h574d3a4e,
      32'ha2ac28dd, 32'h924f2211, 32'hb0a91028, 32'h83a90487, 32'hf22cf6f8, 32'h17a5dcfe,
      32'h10497534, 32'h27dd1316, 32'h94a34815, 32'h276e11ee, 32'head1d779, 32'h0bfd4f20,
      32'h45f2228f, 32'h35d21bf8, 32'h121336c0, 32'h43a6538b, 32'h55e950dc, 32'h88a80871,
      32'hfda9f61e, 32'h5c76d120, 32'h2eb8338f, 32'h5193bb8e, 32'h30a6995c, 32'h500505a8,
      32'h7b214f6a, 32'h6a74558d, 32'h040d0716, 32'h4452846b, 32'hd0a0e838, 32'head282e0,
      32'h6bc6465c, 32'hcb4ab107, 32'hab990ed7, 32'h72a1fe7b, 32'h06901fdf, 32'h18f90739,
      32'h8cd2b861, 32'haea9d40c, 32'h2dcf7c18, 32'h45979e8a, 32'h10393f0d, 32'h3209d7c9,
      32'h2c71378f, 32'h908a692a, 32'hc0e63b24, 32'h05de3118, 32'hfc974436, 32'h1be44823,
      32'h03de2f3d, 32'h66cfb6e4, 32'h52727bfc, 32'ha7b93651, 32'hd7b9035f, 32'hfac28d33,
      32'h59bb4457, 32'heede4004, 32'h175ad747, 32'h7808d123, 32'hc9c97de8, 32'h0c26ca26,
      32'h75e62e96, 32'hc8376e97, 32'hf2ee6baa, 32'h6a885f88, 32'h352f92ab, 32'h4143f4a4,
      32'hb1cca58c, 32'he8fbea94, 32'h5c306621, 32'hfbe64c32, 32'ha1ed285d, 32'hca7395cf,
      32'h4eed31a5, 32'h31e39fee, 32'h7951c585, 32'h23434811, 32'hfc103036, 32'hef001b3c,
      32'h499f5f34, 32'h5f7f38f4, 32'h0206d8c5, 32'hcc3ee4f1, 32'hbc0b485c, 32'h4e4f5829,
      32'h05ee6e6d, 32'hc82d5353, 32'h44892bec, 32'h22984b53, 32'h8a6374d1, 32'h0850c3f9,
      32'h0c06ae88, 32'h2dfdc126, 32'hd1edacdc, 32'h1d8dbd39, 32'hdeff2db8, 32'hd557278d,
      32'h7e9e3740, 32'h49a1ecb5, 32'h43f7b391, 32'h50b6b9ef, 32'h46b9b8f8, 32'hd3f5f6d2,
      32'h8d453b88, 32'hc0ba5333, 32'h5ab92e37, 32'h6e7620a4, 32'h8eb9795a, 32'h30355a84,
      32'hf5e4ad33, 32'h7d0b4df2, 32'he0f3e2a1, 32'ha466f0e6, 32'h39a19c9a, 32'h1b284524,
      32'h854f8b3b, 32'h02d10b6c, 32'h44fb5d9d, 32'h60c29fec, 32'hda35244a, 32'hb5ce6653,
      32'hfd8356ad, 32'hff88d46b, 32'h23fd1d16, 32'hdc0be23c};
    sbox = t;
    generations = 10;
    seed = 0;
    mismatches = 0;
  endfunction

  function bit [31:0] scramble(bit [31:0] k);
    k ^= sbox[k[7:0]];
    k ^= sbox[k[15:8]];
    k ^= sbox[k[23:16]];
    k ^= sbox[k[31:24]];
    return k;
  endfunction

  function longint lattice_value(bit [31:0] xl, bit [31:0] yl, int unsigned gen);
    bit [31:0] key;
    bit [31:0] h;
    key = (((seed << gen) | xl) << gen) | yl;
    h = scramble(key);
    return longint'(h >> 15) - 65536;
  endfunction

  function longint fade(bit [31:0] c, int unsigned g);
    bit [31:0] sh;
    longint f;
    longint f2;
    sh = c << g;
    f = longint'(sh[31:16]);
    f2 = (f * f) >>> 16;
    return (f2 * ((3 << 16) - 2 * f)) >>> 16;
  endfunction

  function longint blend(longint a, longint b, longint s);
    return a + (((b - a) * s) >>> 16);
  endfunction

  function logic signed [17:0] fractal_noise(bit [31:0] x, bit [31:0] y);
    int unsigned gen;
    int unsigned g;
    bit [31:0] xl;
    bit [31:0] yl;
    longint sx;
    longint sy;
    longint p0;
    longint p1;
    longint total;
    gen = generations;
    if (gen < 8) gen = 8;
    if (gen > 24) gen = 24;
    total = 0;
    for (int k = 0; k < 7; k++) begin
      g = gen - 7 + k;
      xl = x >> (32 - g);
      yl = y >> (32 - g);
      sx = fade(x, g);
      sy = fade(y, g);
      p0 = blend(lattice_value(xl, yl, gen), lattice_value(xl, yl + 1, gen), sy);
      p1 = blend(lattice_value(xl + 1, yl, gen), lattice_value(xl + 1, yl + 1, gen), sy);
      total += blend(p0, p1, sx) <<< (6 - k);
    end
    total = total >>> 7;
    if (total > 65536) total = 65536;
    if (total < -65536) total = -65536;
    return total[17:0];
  endfunction

  function void note_point(bit [31:0] x, bit [31:0] y);
    pending_noise.push_back(fractal_noise(x, y));
  endfunction

  function void check_noise(logic signed [17:0] got);
    logic signed [17:0] want;
    if (pending_noise.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected noise word %0d", got);
      return;
    end
    want = pending_noise.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("noise mismatch: expected %0d, got %0d", want, got);
    end
  endfunction
endclass

module lattice_value_noise_octaves_test;
  import lvno_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [31:0] x_coord_i;
  logic [31:0] y_coord_i;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [OutWidth-1:0] noise_value_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [0:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  noise_scoreboard board;
  bit calm;
  int stall_left;
  int idle_cycles;
  bit timed_out;

  lattice_value_noise_octaves dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= gap_len();
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_noise(noise_value_o);
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles > 5000) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_point(bit [31:0] x, bit [31:0] y);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_coord_i <= x;
    y_coord_i <= y;
    do @(posedge clk_i); while (in_stall_o);
    board.note_point(x, y);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending_noise.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_index_e idx, bit [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgGenerations) board.generations = data[4:0];
    else board.seed = data;
  endtask

  task automatic edge_points();
    send_point(32'h0, 32'h0);
    send_point(32'hffffffff, 32'hffffffff);
    send_point(32'h0, 32'hffffffff);
    send_point(32'hffffffff, 32'h0);
    send_point(32'h80000000, 32'h7fffffff);
    send_point(32'hff800000, 32'h00800000);
  endtask

  task automatic random_points(int count);
    bit [31:0] x;
    bit [31:0] y;
    for (int i = 0; i < count; i++) begin
      x = $urandom();
      y = $urandom();
      // near the top edge the corner index overflows into the key
      if ($urandom_range(9) == 0) x = x | 32'hfff00000;
      if ($urandom_range(9) == 0) y = y | 32'hfff00000;
      send_point(x, y);
    end
  endtask

  initial begin
    int gens[10] = '{8, 24, 0, 31, 7, 25, 12, 16, 20, 9};
    board = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    x_coord_i = '0;
    y_coord_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgGenerations;
    cfg_data_i = '0;
    calm = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    edge_points();
    drain();
    write_reg(CfgSeed, 32'hffffffff);
    write_reg(CfgGenerations, 5'd24);
    edge_points();
    drain();
    write_reg(CfgGenerations, 5'd0);
    edge_points();
    drain();

    foreach (gens[i]) begin
      calm = (i % 3 == 2);
      write_reg(CfgGenerations, gens[i]);
      write_reg(CfgSeed, (i == 0) ? 32'h0 : (i == 1) ? 32'hffffffff : $urandom());
      edge_points();
      random_points(120);
      drain();
    end

    if (board.mismatches == 0 && board.pending_noise.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

/* filelist.f */
src/lvno_pkg.sv
src/lvno_octave.sv
src/lattice_value_noise_octaves.sv
tb/lattice_value_noise_octaves_test.sv
